@@ src/top_n_flow_tracker_unit_assert.svh @@
// assertion macros for the checker file
`ifndef TOP_N_FLOW_TRACKER_UNIT_ASSERT_SVH
`define TOP_N_FLOW_TRACKER_UNIT_ASSERT_SVH

// clocked assertion, off while reset is asserted
`define TNFT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tnft assertion failed");

// clocked assertion that also holds through reset
`define TNFT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("tnft assertion failed");

`endif

@@ src/tnft_pkg.sv @@
// shared types, status codes and ranking function of the flow tracker
package tnft_pkg;

  localparam logic [2:0] ST_INSERT  = 3'd0;
  localparam logic [2:0] ST_FWD     = 3'd1;
  localparam logic [2:0] ST_REV     = 3'd2;
  localparam logic [2:0] ST_DROP    = 3'd3;
  localparam logic [2:0] ST_ENTRY   = 3'd4;
  localparam logic [2:0] ST_EMPTY   = 3'd5;

  localparam logic OP_ACCOUNT = 1'b0;
  localparam logic OP_DUMP    = 1'b1;

  typedef struct packed {
    logic        fam;
    logic [63:0] src_hi;
    logic [63:0] src_lo;
    logic [63:0] dst_hi;
    logic [63:0] dst_lo;
    logic [31:0] ports;
    logic [7:0]  proto;
    logic [63:0] rx;
    logic [63:0] tx;
    logic [31:0] pkts;
  } entry_t;

  typedef struct packed {
    logic capture;
    logic match;
    logic sort;
    logic parity;
    logic report;
    logic dump;
  } cmd_t;

  typedef struct packed {
    logic is_dump;
    logic dump_last;
  } stat_t;

  // a ranks strictly above b
  function automatic logic ranks_above(logic mode, entry_t a, entry_t b);
    logic [64:0] sa;
    logic [64:0] sb;
    sa = {1'b0, a.rx} + {1'b0, a.tx};
    sb = {1'b0, b.rx} + {1'b0, b.tx};
    if (mode) return a.pkts > b.pkts;
    return sa > sb;
  endfunction

endpackage

@@ src/top_n_flow_tracker_unit.sv @@
// top level of the ranked bidirectional flow table
// usage:
//   pulse start_i with the request fields while busy_o is low; the request
//   is taken at that edge. operation_i 0 accounts one packet, 1 dumps.
//   an accounted packet gives one result after a match step, TOP_N + 1
//   odd-even sort phases over the table registers and a report step; the
//   sort phase count sets the packet rate, and a new request is taken in
//   the cycle the result shows. a dump gives one result per valid entry
//   in rank order, one per cycle; an empty table gives one result with
//   status table empty. last_o marks the final result of a request. each
//   result stands for one cycle with result_valid_o high; the receiver
//   cannot stall it and must take it then.
//   cfg_we_i writes sort_mode from cfg_wdata_i (0 total bytes, 1 packets);
//   the user must write it only while idle; the block does not enforce
//   this. the new sort_mode applies from the next accounted packet.
//   reset empties the table and clears sort_mode; no clearing pass.
module top_n_flow_tracker_unit #(
  parameter int TOP_N = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        operation_i,
  input  logic        is_ipv6_i,
  input  logic [63:0] src_addr_hi_i,
  input  logic [63:0] src_addr_lo_i,
  input  logic [63:0] dst_addr_hi_i,
  input  logic [63:0] dst_addr_lo_i,
  input  logic [15:0] src_port_i,
  input  logic [15:0] dst_port_i,
  input  logic [7:0]  protocol_number_i,
  input  logic [15:0] packet_length_i,
  output logic        result_valid_o,
  output logic [2:0]  status_o,
  output logic [3:0]  rank_o,
  output logic [63:0] entry_src_hi_o,
  output logic [63:0] entry_src_lo_o,
  output logic [63:0] entry_dst_hi_o,
  output logic [63:0] entry_dst_lo_o,
  output logic [31:0] entry_port_pair_o,
  output logic [8:0]  entry_family_protocol_o,
  output logic [63:0] entry_rx_bytes_o,
  output logic [63:0] entry_tx_bytes_o,
  output logic [31:0] entry_packets_o,
  output logic        last_o
);
  import tnft_pkg::*;

  cmd_t   cmd;
  stat_t  stat;
  entry_t res;

  tnft_ctrl #(.TOP_N(TOP_N)) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  tnft_datapath #(.TOP_N(TOP_N)) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .operation_i      (operation_i),
    .is_ipv6_i        (is_ipv6_i),
    .src_addr_hi_i    (src_addr_hi_i),
    .src_addr_lo_i    (src_addr_lo_i),
    .dst_addr_hi_i    (dst_addr_hi_i),
    .dst_addr_lo_i    (dst_addr_lo_i),
    .src_port_i       (src_port_i),
    .dst_port_i       (dst_port_i),
    .protocol_number_i(protocol_number_i),
    .packet_length_i  (packet_length_i),
    .result_valid_o   (result_valid_o),
    .status_o         (status_o),
    .rank_o           (rank_o),
    .res_o            (res),
    .last_o           (last_o)
  );

  assign entry_src_hi_o          = res.src_hi;
  assign entry_src_lo_o          = res.src_lo;
  assign entry_dst_hi_o          = res.dst_hi;
  assign entry_dst_lo_o          = res.dst_lo;
  assign entry_port_pair_o       = res.ports;
  assign entry_family_protocol_o = {res.fam, res.proto};
  assign entry_rx_bytes_o        = res.rx;
  assign entry_tx_bytes_o        = res.tx;
  assign entry_packets_o         = res.pkts;

endmodule

@@ src/tnft_ctrl.sv @@
// sequencer for capture, match, sort phases, report and dump
module tnft_ctrl #(
  parameter int TOP_N = 10
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  tnft_pkg::stat_t stat_i,
  output tnft_pkg::cmd_t  cmd_o
);
  import tnft_pkg::*;

  localparam int SLOTS = TOP_N + 1;
  localparam int PW = $clog2(SLOTS);

  typedef enum logic [2:0] {S_IDLE, S_MATCH, S_SORT, S_REPORT, S_DUMP} state_e;

  state_e        state_q, state_d;
  logic [PW-1:0] phase_q, phase_d;
  logic          busy_q;

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_MATCH;
        end
      end
      S_MATCH: begin
        phase_d = '0;
        if (stat_i.is_dump) begin
          state_d = S_DUMP;
        end else begin
          cmd_o.match = 1'b1;
          state_d = S_SORT;
        end
      end
      S_SORT: begin
        cmd_o.sort   = 1'b1;
        cmd_o.parity = phase_q[0];
        phase_d = phase_q + 1'b1;
        if (phase_q == PW'(SLOTS - 1)) state_d = S_REPORT;
      end
      S_REPORT: begin
        cmd_o.report = 1'b1;
        state_d = S_IDLE;
      end
      S_DUMP: begin
        cmd_o.dump = 1'b1;
        if (stat_i.dump_last) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= '0;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      busy_q  <= (state_d != S_IDLE);
    end
  end

  assign busy_o = busy_q;

endmodule

@@ src/tnft_datapath.sv @@
// flow table, match logic, odd-even sort network step and result registers
module tnft_datapath #(
  parameter int TOP_N = 10
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tnft_pkg::cmd_t  cmd_i,
  output tnft_pkg::stat_t stat_o,
  input  logic            cfg_we_i,
  input  logic            cfg_wdata_i,
  input  logic            operation_i,
  input  logic            is_ipv6_i,
  input  logic [63:0]     src_addr_hi_i,
  input  logic [63:0]     src_addr_lo_i,
  input  logic [63:0]     dst_addr_hi_i,
  input  logic [63:0]     dst_addr_lo_i,
  input  logic [15:0]     src_port_i,
  input  logic [15:0]     dst_port_i,
  input  logic [7:0]      protocol_number_i,
  input  logic [15:0]     packet_length_i,
  output logic            result_valid_o,
  output logic [2:0]      status_o,
  output logic [3:0]      rank_o,
  output tnft_pkg::entry_t res_o,
  output logic            last_o
);
  import tnft_pkg::*;

  localparam int SLOTS = TOP_N + 1;
  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  entry_t        tbl_q [SLOTS];
  entry_t        tbl_d [SLOTS];
  logic [CW-1:0] count_q, count_d;
  logic [IW-1:0] touched_q, touched_d;
  logic [IW-1:0] ptr_q, ptr_d;
  logic [2:0]    st_q, st_d;
  logic          mode_q;
  logic          op_q;
  entry_t        pkt_q;
  logic [15:0]   len_q;

  logic          res_valid_q;
  logic [2:0]    res_status_q;
  logic [3:0]    res_rank_q;
  entry_t        res_q;
  logic          res_last_q;

  logic          found;
  logic [IW-1:0] hit_idx;
  logic          hit_fwd;
  logic [64:0]   sum65;
  logic          dropped;

  assign stat_o.is_dump   = (op_q == OP_DUMP);
  assign stat_o.dump_last = (count_q == '0) || ({{(CW-IW){1'b0}}, ptr_q} == count_q - 1'b1);
  assign dropped = (count_q == CW'(SLOTS)) && (touched_q == IW'(TOP_N));

  always_comb begin
    entry_t e;
    tbl_d     = tbl_q;
    count_d   = count_q;
    touched_d = touched_q;
    ptr_d     = ptr_q;
    st_d      = st_q;
    found     = 1'b0;
    hit_idx   = '0;
    hit_fwd   = 1'b0;
    sum65     = '0;
    e         = '0;

    if (cmd_i.capture) ptr_d = '0;

    if (cmd_i.match) begin
      // first entry in rank order wins; within an entry, forward before reverse
      for (int i = 0; i < SLOTS; i++) begin
        if (!found && (CW'(i) < count_q) && tbl_q[i].fam == pkt_q.fam &&
            tbl_q[i].proto == pkt_q.proto) begin
          if (tbl_q[i].src_hi == pkt_q.src_hi && tbl_q[i].src_lo == pkt_q.src_lo &&
              tbl_q[i].dst_hi == pkt_q.dst_hi && tbl_q[i].dst_lo == pkt_q.dst_lo &&
              tbl_q[i].ports == pkt_q.ports) begin
            found = 1'b1; hit_fwd = 1'b1; hit_idx = IW'(i);
          end else if (tbl_q[i].src_hi == pkt_q.dst_hi && tbl_q[i].src_lo == pkt_q.dst_lo &&
                       tbl_q[i].dst_hi == pkt_q.src_hi && tbl_q[i].dst_lo == pkt_q.src_lo &&
                       tbl_q[i].ports == {pkt_q.ports[15:0], pkt_q.ports[31:16]}) begin
            found = 1'b1; hit_idx = IW'(i);
          end
        end
      end
      if (found) begin
        e = tbl_q[hit_idx];
        sum65 = {1'b0, hit_fwd ? e.rx : e.tx} + {49'd0, len_q};
        if (hit_fwd) e.rx = sum65[64] ? '1 : sum65[63:0];
        else         e.tx = sum65[64] ? '1 : sum65[63:0];
        if (e.pkts != '1) e.pkts = e.pkts + 1'b1;
        tbl_d[hit_idx] = e;
        touched_d = hit_idx;
        st_d = hit_fwd ? ST_FWD : ST_REV;
      end else begin
        e = pkt_q;
        e.rx = {48'd0, len_q};
        e.tx = '0;
        e.pkts = 32'd1;
        tbl_d[count_q[IW-1:0]] = e;
        touched_d = count_q[IW-1:0];
        count_d = count_q + 1'b1;
        st_d = ST_INSERT;
      end
    end

    if (cmd_i.sort) begin
      // one odd-even transposition phase; swap only on strict order keeps it stable
      for (int j = 0; j < SLOTS - 1; j++) begin
        if (((j % 2) == int'(cmd_i.parity)) && (CW'(j + 1) < count_q) &&
            ranks_above(mode_q, tbl_q[j+1], tbl_q[j])) begin
          tbl_d[j]   = tbl_q[j+1];
          tbl_d[j+1] = tbl_q[j];
          if (touched_q == IW'(j)) touched_d = IW'(j + 1);
          else if (touched_q == IW'(j + 1)) touched_d = IW'(j);
        end
      end
    end

    if (cmd_i.report && count_q == CW'(SLOTS)) count_d = CW'(TOP_N);
    if (cmd_i.dump) ptr_d = ptr_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      mode_q      <= 1'b0;
      res_valid_q <= 1'b0;
      op_q        <= OP_ACCOUNT;
      ptr_q       <= '0;
    end else begin
      count_q     <= count_d;
      ptr_q       <= ptr_d;
      res_valid_q <= cmd_i.report || cmd_i.dump;
      if (cfg_we_i) mode_q <= cfg_wdata_i;
      if (cmd_i.capture) op_q <= operation_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tbl_q     <= tbl_d;
    touched_q <= touched_d;
    st_q      <= st_d;
    if (cmd_i.capture) begin
      pkt_q.fam    <= is_ipv6_i;
      pkt_q.src_hi <= src_addr_hi_i;
      pkt_q.src_lo <= src_addr_lo_i;
      pkt_q.dst_hi <= dst_addr_hi_i;
      pkt_q.dst_lo <= dst_addr_lo_i;
      pkt_q.ports  <= {src_port_i, dst_port_i};
      pkt_q.proto  <= protocol_number_i;
      pkt_q.rx     <= '0;
      pkt_q.tx     <= '0;
      pkt_q.pkts   <= '0;
      len_q        <= packet_length_i;
    end
    if (cmd_i.report) begin
      res_status_q <= dropped ? ST_DROP : st_q;
      res_rank_q   <= 4'(touched_q);
      res_q        <= tbl_q[touched_q];
      res_last_q   <= 1'b1;
    end else if (cmd_i.dump) begin
      if (count_q == '0) begin
        res_status_q <= ST_EMPTY;
        res_rank_q   <= '0;
        res_q        <= '0;
      end else begin
        res_status_q <= ST_ENTRY;
        res_rank_q   <= 4'(ptr_q);
        res_q        <= tbl_q[ptr_q];
      end
      res_last_q <= stat_o.dump_last;
    end
  end

  assign result_valid_o = res_valid_q;
  assign status_o       = res_status_q;
  assign rank_o         = res_rank_q;
  assign res_o          = res_q;
  assign last_o         = res_last_q;

endmodule

@@ src/tnft_checker.sv @@
// port-level checks of the flow tracker, bound to the top level
`include "top_n_flow_tracker_unit_assert.svh"

module tnft_checker #(
  parameter int TOP_N = 10
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       result_valid_o,
  input logic [2:0] status_o,
  input logic [3:0] rank_o,
  input logic       last_o
);
  import tnft_pkg::*;

  `TNFT_ASSERT(a_accept_busy, start_i && !busy_o |=> busy_o)
  `TNFT_ASSERT(a_last_idle, result_valid_o && last_o |-> !busy_o)
  `TNFT_ASSERT(a_idle_only_last, !busy_o && result_valid_o |-> last_o)
  `TNFT_ASSERT(a_drop_rank, result_valid_o && status_o == ST_DROP |-> rank_o == 4'(TOP_N))
  `TNFT_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !busy_o && !result_valid_o)

endmodule

bind top_n_flow_tracker_unit tnft_checker #(.TOP_N(TOP_N)) u_tnft_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .result_valid_o(result_valid_o),
  .status_o      (status_o),
  .rank_o        (rank_o),
  .last_o        (last_o)
);
